@@ sv/vca_pkg.sv @@
// ----------------------------------------------------------------------------
// vca_pkg
// Shared types and constants of the VOLE column accumulator.
// ----------------------------------------------------------------------------
package vca_pkg;

  localparam int unsigned DefMaxTreeDepth = 12;
  localparam int unsigned DefMaxWords     = 128;
  localparam int unsigned DefMaxTrees     = 32;

  localparam int unsigned WordW     = 64;
  localparam int unsigned TreeNumW  = 5;
  localparam int unsigned SeedNumW  = 12;
  localparam int unsigned WordNumW  = 7;
  localparam int unsigned RowNumW   = 4;
  localparam int unsigned DepthW    = 5;
  localparam int unsigned RowMaskW  = 16;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned InDataW   = 104;
  localparam int unsigned OutDataW  = 80;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CfgAddrW-1:0] CFG_MODE        = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_DEEP_COUNT  = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_FIRST_DEPTH = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_SECOND_DEPTH = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_ROW_WORDS   = 3'd4;

  localparam logic MODE_PROVER   = 1'b0;
  localparam logic MODE_VERIFIER = 1'b1;

  typedef enum logic [1:0] {
    KIND_SUM  = 2'd0,
    KIND_CORR = 2'd1,
    KIND_ROW  = 2'd2
  } kind_e;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic [WordNumW-1:0] word;
    logic                seed_zero;
    logic [RowMaskW-1:0] row_hit;
    logic [WordW-1:0]    rnd;
    logic                prover;
    logic                tree_zero;
    logic                last;
    logic [DepthW-1:0]   depth;
  } entry_t;

  // Control of one result burst handed from the back to the emitter.
  typedef struct packed {
    logic                has_head;
    kind_e               head_kind;
    logic [WordW-1:0]    head_data;
    logic [DepthW-1:0]   depth;
    logic [WordNumW-1:0] word;
  } emit_ctl_t;

endpackage

@@ sv/vca_ram.sv @@
// ----------------------------------------------------------------------------
// vca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vca_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/vca_front.sv @@
// ----------------------------------------------------------------------------
// vca_front
// Configuration registers and classification of incoming words.
// ----------------------------------------------------------------------------
module vca_front #(
  parameter int unsigned MAX_TREE_DEPTH = vca_pkg::DefMaxTreeDepth,
  parameter int unsigned MAX_WORDS      = vca_pkg::DefMaxWords,
  parameter int unsigned MAX_TREES      = vca_pkg::DefMaxTrees
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vca_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  logic [vca_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [vca_pkg::TreeNumW-1:0]        tree_number_i,
  input  logic [vca_pkg::SeedNumW-1:0]        seed_number_i,
  input  logic [vca_pkg::WordNumW-1:0]        word_number_i,
  input  logic [vca_pkg::WordW-1:0]           random_word_i,
  input  logic [vca_pkg::SeedNumW-1:0]        hidden_index_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output vca_pkg::entry_t                     q_entry_o
);

  import vca_pkg::*;

  logic       mode_q;
  logic [5:0] deep_q;
  logic [3:0] first_q;
  logic [3:0] second_q;
  logic [7:0] words_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PROVER;
      deep_q   <= 6'd11;
      first_q  <= 4'd12;
      second_q <= 4'd11;
      words_q  <= 8'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MODE:         mode_q   <= cfg_wdata_i[0];
        CFG_DEEP_COUNT:   deep_q   <= cfg_wdata_i[5:0];
        CFG_FIRST_DEPTH:  first_q  <= cfg_wdata_i[3:0];
        CFG_SECOND_DEPTH: second_q <= cfg_wdata_i[3:0];
        CFG_ROW_WORDS:    words_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [3:0]          depth_raw;
  logic [DepthW-1:0]   depth;
  logic [16:0]         seed_mask;
  logic [16:0]         seed_ext;
  logic [RowMaskW-1:0] sel;
  logic                tree_ok;
  logic                word_ok;
  logic                seed_ok;

  always_comb begin
    depth_raw = (6'(tree_number_i) < deep_q) ? first_q : second_q;
    if (depth_raw == 4'd0) begin
      depth = DepthW'(1);
    end else if (DepthW'(depth_raw) > DepthW'(MAX_TREE_DEPTH)) begin
      depth = DepthW'(MAX_TREE_DEPTH);
    end else begin
      depth = DepthW'(depth_raw);
    end
    seed_mask = (17'd1 << depth) - 17'd1;
    seed_ext  = 17'(seed_number_i);
    sel = (mode_q == MODE_VERIFIER) ? RowMaskW'(seed_number_i ^ hidden_index_i)
                                    : RowMaskW'(seed_number_i);
    tree_ok = 7'(tree_number_i) < 7'(MAX_TREES);
    word_ok = (10'(word_number_i) < 10'(words_q)) &&
              (10'(word_number_i) < 10'(MAX_WORDS));
    seed_ok = seed_ext <= seed_mask;
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && tree_ok && word_ok && seed_ok;

  assign q_entry_o.word      = word_number_i;
  assign q_entry_o.seed_zero = (seed_number_i == '0);
  assign q_entry_o.row_hit   = seed_mask[RowMaskW-1:0] & sel;
  assign q_entry_o.rnd       = random_word_i;
  assign q_entry_o.prover    = (mode_q == MODE_PROVER);
  assign q_entry_o.tree_zero = (tree_number_i == '0);
  assign q_entry_o.last      = (seed_ext == seed_mask);
  assign q_entry_o.depth     = depth;

endmodule

@@ sv/vca_queue.sv @@
// ----------------------------------------------------------------------------
// vca_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module vca_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vca_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output vca_pkg::entry_t entry_o
);

  import vca_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rptr_q];

endmodule

@@ sv/vca_back.sv @@
// ----------------------------------------------------------------------------
// vca_back
// Read-modify-write of the per-word accumulators and hand-off of finished
// columns to the emitter.
// ----------------------------------------------------------------------------
module vca_back #(
  parameter int unsigned MAX_TREE_DEPTH = vca_pkg::DefMaxTreeDepth,
  parameter int unsigned MAX_WORDS      = vca_pkg::DefMaxWords
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          q_valid_i,
  input  vca_pkg::entry_t                               q_entry_i,
  output logic                                          q_pop_o,
  input  logic                                          emit_free_i,
  output logic                                          emit_load_o,
  output vca_pkg::emit_ctl_t                            emit_ctl_o,
  output logic [MAX_TREE_DEPTH-1:0][vca_pkg::WordW-1:0] emit_rows_o
);

  import vca_pkg::*;

  localparam int unsigned AddrW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned TreeOff = MAX_TREE_DEPTH * WordW;
  localparam int unsigned FirstOff = (MAX_TREE_DEPTH + 1) * WordW;
  localparam int unsigned LineW   = (MAX_TREE_DEPTH + 2) * WordW;

  entry_t           s1_q;
  logic             s1_valid_q, s1_valid_d;
  logic             byp_hit_q;
  logic [LineW-1:0] byp_data_q;
  logic [LineW-1:0] rdata;
  logic [LineW-1:0] old_line;
  logic [LineW-1:0] new_line;
  logic             s1_exec;
  logic             pop;
  logic [WordW-1:0] tree_new;
  logic [WordW-1:0] first_old;
  logic [WordW-1:0] base;

  assign s1_exec = s1_valid_q && (!s1_q.last || emit_free_i);
  assign pop     = q_valid_i && (!s1_valid_q || s1_exec);
  assign q_pop_o = pop;

  vca_ram #(
    .WIDTH (LineW),
    .DEPTH (MAX_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (s1_exec),
    .waddr_i (AddrW'(s1_q.word)),
    .wdata_i (new_line),
    .re_i    (pop),
    .raddr_i (AddrW'(q_entry_i.word)),
    .rdata_o (rdata)
  );

  assign old_line = byp_hit_q ? byp_data_q : rdata;

  always_comb begin
    new_line = old_line;
    for (int j = 0; j < MAX_TREE_DEPTH; j++) begin
      base = s1_q.seed_zero ? '0 : old_line[j*WordW +: WordW];
      new_line[j*WordW +: WordW] = base ^ (s1_q.row_hit[j] ? s1_q.rnd : '0);
      emit_rows_o[j] = new_line[j*WordW +: WordW];
    end
    first_old = old_line[FirstOff +: WordW];
    tree_new  = (s1_q.seed_zero ? '0 : old_line[TreeOff +: WordW]) ^
                (s1_q.prover ? s1_q.rnd : '0);
    new_line[TreeOff +: WordW] = tree_new;
    new_line[FirstOff +: WordW] =
        (s1_q.prover && s1_q.tree_zero && s1_q.last) ? tree_new : first_old;
  end

  assign emit_load_o          = s1_exec && s1_q.last;
  assign emit_ctl_o.has_head  = s1_q.prover;
  assign emit_ctl_o.head_kind = s1_q.tree_zero ? KIND_SUM : KIND_CORR;
  assign emit_ctl_o.head_data = s1_q.tree_zero ? tree_new : (first_old ^ tree_new);
  assign emit_ctl_o.depth     = s1_q.depth;
  assign emit_ctl_o.word      = s1_q.word;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop) begin
      s1_valid_d = 1'b1;
    end else if (s1_exec) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (pop) begin
        byp_hit_q <= s1_exec && (s1_q.word == q_entry_i.word);
      end
    end
  end

  // A word read in the same cycle as a write to it sees the old line, so the
  // freshly written line is kept and used in its place.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_q       <= q_entry_i;
      byp_data_q <= new_line;
    end
  end

endmodule

@@ sv/vca_emit.sv @@
// ----------------------------------------------------------------------------
// vca_emit
// Holds one finished column and sends its results out one word at a time.
// ----------------------------------------------------------------------------
module vca_emit #(
  parameter int unsigned MAX_TREE_DEPTH = vca_pkg::DefMaxTreeDepth
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          load_i,
  input  vca_pkg::emit_ctl_t                            ctl_i,
  input  logic [MAX_TREE_DEPTH-1:0][vca_pkg::WordW-1:0] rows_i,
  output logic                                          free_o,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output vca_pkg::kind_e                                out_kind_o,
  output logic [vca_pkg::RowNumW-1:0]                   out_row_o,
  output logic [vca_pkg::WordNumW-1:0]                  out_word_o,
  output logic [vca_pkg::WordW-1:0]                     out_data_o,
  output logic                                          out_last_o
);

  import vca_pkg::*;

  localparam int unsigned RowIdxW = (MAX_TREE_DEPTH > 1) ? $clog2(MAX_TREE_DEPTH) : 1;

  logic                                 busy_q, busy_d;
  logic                                 head_q, head_d;
  logic [RowIdxW-1:0]                   idx_q, idx_d;
  emit_ctl_t                            ctl_q;
  logic [MAX_TREE_DEPTH-1:0][WordW-1:0] rows_q;
  logic                                 row_last;
  logic                                 fire;

  assign row_last = (DepthW'(idx_q) == ctl_q.depth - DepthW'(1));
  assign fire     = busy_q && out_ready_i;

  assign out_valid_o = busy_q;
  assign out_kind_o  = head_q ? ctl_q.head_kind : KIND_ROW;
  assign out_row_o   = head_q ? '0 : RowNumW'(idx_q);
  assign out_word_o  = ctl_q.word;
  assign out_data_o  = head_q ? ctl_q.head_data : rows_q[idx_q];
  assign out_last_o  = !head_q && row_last;
  assign free_o      = !busy_q || (out_ready_i && out_last_o);

  always_comb begin
    busy_d = busy_q;
    head_d = head_q;
    idx_d  = idx_q;
    if (fire) begin
      if (head_q) begin
        head_d = 1'b0;
      end else if (row_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + RowIdxW'(1);
      end
    end
    if (load_i) begin
      busy_d = 1'b1;
      head_d = ctl_i.has_head;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      head_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      head_q <= head_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ctl_q  <= ctl_i;
      rows_q <= rows_i;
    end
  end

endmodule

@@ sv/vole_column_accumulate.sv @@
// ----------------------------------------------------------------------------
// vole_column_accumulate
// Accumulates expanded seed words into per-tree sums and row words.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while its queue has room. Each word is
// classified on entry, queued, and folded into its word position with a
// read-modify-write of one wide line of accumulator RAM (rows, tree sum,
// first-tree sum), with the line just written forwarded to a following word
// of the same position. A word of a tree's last seed sends out a burst of
// depth results, plus one leading sum or correction word in prover mode, one
// result per cycle while m_axis_tready is high; the back waits only when a
// second burst is ready before the first is out. Accumulator contents are
// not cleared by reset; seed zero of a word position starts it anew.
module vole_column_accumulate #(
  parameter int unsigned MAX_TREE_DEPTH = vca_pkg::DefMaxTreeDepth,
  parameter int unsigned MAX_WORDS      = vca_pkg::DefMaxWords,
  parameter int unsigned MAX_TREES      = vca_pkg::DefMaxTrees
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vca_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [vca_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tree_number, seed_number, word_number, random_word, hidden_index
  input  logic [vca_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // row_number, out_word_number, data_word
  output logic [vca_pkg::OutDataW-1:0]  m_axis_tdata,
  // kind
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);

  import vca_pkg::*;

  entry_t                               push_entry;
  entry_t                               head_entry;
  logic                                 q_push;
  logic                                 q_full;
  logic                                 q_pop;
  logic                                 q_valid;
  logic                                 emit_free;
  logic                                 emit_load;
  emit_ctl_t                            emit_ctl;
  logic [MAX_TREE_DEPTH-1:0][WordW-1:0] emit_rows;
  kind_e                                out_kind;
  logic [RowNumW-1:0]                   out_row;
  logic [WordNumW-1:0]                  out_word;
  logic [WordW-1:0]                     out_data;

  vca_front #(
    .MAX_TREE_DEPTH (MAX_TREE_DEPTH),
    .MAX_WORDS      (MAX_WORDS),
    .MAX_TREES      (MAX_TREES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .tree_number_i  (s_axis_tdata[4:0]),
    .seed_number_i  (s_axis_tdata[16:5]),
    .word_number_i  (s_axis_tdata[23:17]),
    .random_word_i  (s_axis_tdata[87:24]),
    .hidden_index_i (s_axis_tdata[99:88]),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (push_entry)
  );

  vca_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  vca_back #(
    .MAX_TREE_DEPTH (MAX_TREE_DEPTH),
    .MAX_WORDS      (MAX_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .emit_free_i (emit_free),
    .emit_load_o (emit_load),
    .emit_ctl_o  (emit_ctl),
    .emit_rows_o (emit_rows)
  );

  vca_emit #(
    .MAX_TREE_DEPTH (MAX_TREE_DEPTH)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit_load),
    .ctl_i       (emit_ctl),
    .rows_i      (emit_rows),
    .free_o      (emit_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_row_o   (out_row),
    .out_word_o  (out_word),
    .out_data_o  (out_data),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_data, out_word, out_row};
  assign m_axis_tuser = out_kind;

endmodule

@@ tb/column_sum_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// column_sum_checker
// Watches the configuration port and both streams of the VOLE column
// accumulator, predicts each output word from the accepted seed words and
// compares it field by field, in order, with what the block sends out.
// ----------------------------------------------------------------------------
module column_sum_checker
  import vca_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic [1:0]          m_axis_tuser,
  input  logic                m_axis_tlast,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);

  typedef struct packed {
    logic [3:0]          pad;
    logic [SeedNumW-1:0] hidden;
    logic [WordW-1:0]    rnd;
    logic [WordNumW-1:0] word;
    logic [SeedNumW-1:0] seed;
    logic [TreeNumW-1:0] tree;
  } seed_word_t;

  typedef struct packed {
    logic [4:0]          pad;
    logic [WordW-1:0]    data;
    logic [WordNumW-1:0] word;
    logic [RowNumW-1:0]  row;
  } out_word_t;

  typedef struct packed {
    kind_e               kind;
    logic [RowNumW-1:0]  row;
    logic [WordNumW-1:0] word;
    logic [WordW-1:0]    data;
    logic                last;
  } column_result_t;

  logic [WordW-1:0] row_acc [DefMaxTreeDepth][DefMaxWords];
  logic [WordW-1:0] tree_acc [DefMaxWords];
  logic [WordW-1:0] first_acc [DefMaxWords];

  logic       mode;
  logic [5:0] deep_count;
  logic [3:0] first_depth;
  logic [3:0] second_depth;
  logic [7:0] row_words;

  column_result_t due_results[$];
  int unsigned    mismatches;
  int unsigned    checked;

  task automatic queue_result(input kind_e kind, input int unsigned row,
                              input logic [WordNumW-1:0] word,
                              input logic [WordW-1:0] data, input logic last);
    column_result_t r;
    r.kind = kind;
    r.row  = row[RowNumW-1:0];
    r.word = word;
    r.data = data;
    r.last = last;
    due_results.push_back(r);
  endtask

  task automatic fold_word(input seed_word_t w);
    int unsigned         depth;
    int unsigned         limit;
    int unsigned         j;
    logic [SeedNumW-1:0] mask;
    logic [SeedNumW-1:0] sel;
    depth = (w.tree < deep_count) ? first_depth : second_depth;
    if (depth == 0) begin
      depth = 1;
    end else if (depth > DefMaxTreeDepth) begin
      depth = DefMaxTreeDepth;
    end
    limit = (row_words < DefMaxWords) ? row_words : DefMaxWords;
    mask  = SeedNumW'((1 << depth) - 1);
    if (w.word >= limit || w.seed > mask) begin
      return;
    end
    if (w.seed == 0) begin
      tree_acc[w.word] = '0;
      for (j = 0; j < DefMaxTreeDepth; j++) begin
        row_acc[j][w.word] = '0;
      end
    end
    sel = (mode == MODE_VERIFIER) ? ((w.seed ^ w.hidden) & mask) : w.seed;
    if (mode == MODE_PROVER) begin
      tree_acc[w.word] ^= w.rnd;
    end
    for (j = 0; j < depth; j++) begin
      if (sel[j]) begin
        row_acc[j][w.word] ^= w.rnd;
      end
    end
    if (w.seed != mask) begin
      return;
    end
    if (mode == MODE_PROVER) begin
      if (w.tree == 0) begin
        first_acc[w.word] = tree_acc[w.word];
        queue_result(KIND_SUM, 0, w.word, tree_acc[w.word], 1'b0);
      end else begin
        queue_result(KIND_CORR, 0, w.word, first_acc[w.word] ^ tree_acc[w.word], 1'b0);
      end
    end
    for (j = 0; j < depth; j++) begin
      queue_result(KIND_ROW, j, w.word, row_acc[j][w.word], j == depth - 1);
    end
  endtask

  task automatic compare_field(input string name, input logic [WordW-1:0] want,
                               input logic [WordW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input out_word_t got, input logic [1:0] kind,
                              input logic last);
    column_result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual kind %0d row %0d word %0d data %h",
               $time, kind, got.row, got.word, got.data);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    checked++;
    compare_field("kind", want.kind, kind);
    compare_field("row", want.row, got.row);
    compare_field("word number", want.word, got.word);
    compare_field("data", want.data, got.data);
    compare_field("last", want.last, last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode         <= MODE_PROVER;
      deep_count   <= 6'd11;
      first_depth  <= 4'd12;
      second_depth <= 4'd11;
      row_words    <= 8'd64;
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_MODE:         mode         <= cfg_wdata_i[0];
          CFG_DEEP_COUNT:   deep_count   <= cfg_wdata_i[5:0];
          CFG_FIRST_DEPTH:  first_depth  <= cfg_wdata_i[3:0];
          CFG_SECOND_DEPTH: second_depth <= cfg_wdata_i[3:0];
          CFG_ROW_WORDS:    row_words    <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fold_word(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
      mismatches_o <= mismatches;
      pending_o    <= due_results.size();
      checked_o    <= checked;
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives seed words into the VOLE column accumulator under several register
// settings in prover and verifier mode, first a directed set of corner
// cases and then random accumulation runs, with random stalls on both
// streams. A separate checker predicts and compares every output word.
// ----------------------------------------------------------------------------
module testbench;
  import vca_pkg::*;

  localparam int unsigned RandomItems = 450;
  localparam int unsigned DrainCycles = 32;
  localparam int unsigned IdleLimit   = 4000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = CFG_MODE;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  logic       cur_mode      = MODE_PROVER;
  logic [5:0] cur_deep      = 6'd11;
  logic [3:0] cur_first     = 4'd12;
  logic [3:0] cur_second    = 4'd11;
  logic [7:0] cur_row_words = 8'd64;

  bit          acc_started [DefMaxWords];
  bit          first_done [DefMaxWords];
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 70;
  int unsigned items_total;
  int unsigned items_counted;
  int unsigned settings_used;
  int unsigned quiet_cycles;

  vole_column_accumulate dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  column_sum_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int unsigned depth_for_tree(input logic [TreeNumW-1:0] tree);
    int unsigned depth;
    depth = (tree < cur_deep) ? cur_first : cur_second;
    if (depth == 0) begin
      depth = 1;
    end else if (depth > DefMaxTreeDepth) begin
      depth = DefMaxTreeDepth;
    end
    return depth;
  endfunction

  function automatic int unsigned words_in_use();
    return (cur_row_words < DefMaxWords) ? cur_row_words : DefMaxWords;
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [3:0] pick_depth();
    case ($urandom_range(9))
      0: return 4'd12;
      1: return $urandom_range(1) ? 4'd0 : 4'($urandom_range(13, 15));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_word(input logic [InDataW-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
  endtask

  task automatic send_item(input logic [TreeNumW-1:0] tree, input logic [SeedNumW-1:0] seed_in,
                           input logic [WordNumW-1:0] word, input logic [WordW-1:0] rnd,
                           input logic [SeedNumW-1:0] hidden);
    logic [SeedNumW-1:0] seed;
    int unsigned         mask;
    seed = seed_in;
    mask = (1 << depth_for_tree(tree)) - 1;
    if (word < words_in_use() && seed <= mask) begin
      // A position is only read once a start word has cleared it, and a
      // correction only once tree zero has finished that position.
      if (!acc_started[word]) begin
        seed = '0;
      end
      if (cur_mode == MODE_PROVER && seed == mask && tree != 0 && !first_done[word]) begin
        seed = '0;
      end
      if (seed == 0) begin
        acc_started[word] = 1'b1;
      end
      if (cur_mode == MODE_PROVER && seed == mask && tree == 0) begin
        first_done[word] = 1'b1;
      end
      items_counted++;
    end
    items_total++;
    send_word({4'b0, hidden, rnd, word, seed, tree});
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic mode, input logic [5:0] deep, input logic [3:0] first,
                            input logic [3:0] second, input logic [7:0] row_words);
    wait_idle();
    write_reg(CFG_MODE, {7'b0, mode});
    write_reg(CFG_DEEP_COUNT, {2'b0, deep});
    write_reg(CFG_FIRST_DEPTH, {4'b0, first});
    write_reg(CFG_SECOND_DEPTH, {4'b0, second});
    write_reg(CFG_ROW_WORDS, row_words);
    cfg_we_i      <= 1'b0;
    cur_mode      = mode;
    cur_deep      = deep;
    cur_first     = first;
    cur_second    = second;
    cur_row_words = row_words;
    settings_used++;
  endtask

  task automatic random_config();
    logic [5:0] deep;
    logic [7:0] row_words;
    case ($urandom_range(3))
      0: deep = 6'd0;
      1: deep = 6'd32;
      2: deep = 6'($urandom_range(63));
      default: deep = 6'($urandom_range(1, 4));
    endcase
    case ($urandom_range(3))
      0: row_words = 8'($urandom_range(1, 8));
      1: row_words = 8'($urandom_range(1, 255));
      2: row_words = $urandom_range(1) ? 8'd128 : 8'd255;
      default: row_words = 8'($urandom_range(1, 32));
    endcase
    set_config(1'($urandom_range(1)), deep, pick_depth(), pick_depth(), row_words);
  endtask

  task automatic noise_item();
    send_item(TreeNumW'($urandom_range(31)), SeedNumW'($urandom_range(4095)),
              WordNumW'($urandom_range(127)), rand_word(), SeedNumW'($urandom_range(4095)));
  endtask

  task automatic run_sequence();
    logic [TreeNumW-1:0] tree;
    logic [WordNumW-1:0] word;
    logic [SeedNumW-1:0] hidden;
    int unsigned         mask;
    tree = TreeNumW'($urandom_range(31));
    word = WordNumW'($urandom_range(words_in_use() - 1));
    if (cur_mode == MODE_PROVER && (!first_done[word] || $urandom_range(3) == 0)) begin
      tree = '0;
    end
    mask   = (1 << depth_for_tree(tree)) - 1;
    hidden = SeedNumW'($urandom_range(4095));
    if ($urandom_range(4) != 0) begin
      send_item(tree, '0, word, rand_word(), hidden);
    end
    repeat ($urandom_range(3)) begin
      if ($urandom_range(6) == 0) begin
        noise_item();
      end else begin
        send_item(tree, SeedNumW'($urandom_range(mask)), word, rand_word(), hidden);
      end
    end
    send_item(tree, SeedNumW'(mask), word, rand_word(), hidden);
  endtask

  initial begin
    int unsigned random_start;
    int unsigned phase_end;
    int unsigned progress;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: prover, trees 0 to 10 of depth 12, the rest of depth 11.
    send_item(0, 0, 0, '1, 0);
    send_item(0, 0, 63, '0, 0);
    send_item(0, 12'd2730, 0, rand_word(), 12'd4095);
    send_item(0, 12'd4095, 0, '0, 0);
    send_item(0, 12'd4095, 63, '1, 0);
    send_item(31, 0, 0, rand_word(), 0);
    send_item(31, 12'd2047, 0, '1, 12'd4095);
    send_item(31, 12'd2048, 0, rand_word(), 0);
    send_item(5, 0, 64, rand_word(), 0);
    send_item(31, 0, 127, rand_word(), 0);

    set_config(MODE_VERIFIER, 6'd0, 4'd0, 4'd0, 8'd255);
    send_item(17, 0, 127, rand_word(), 12'd4095);
    send_item(17, 1, 127, rand_word(), 12'd4095);
    send_item(3, 2, 127, rand_word(), 0);

    set_config(MODE_VERIFIER, 6'd32, 4'd15, 4'd1, 8'd128);
    send_item(31, 0, 100, '1, 12'd4095);
    send_item(31, 12'd4095, 100, rand_word(), 12'd4095);

    set_config(MODE_PROVER, 6'd63, 4'd13, 4'd12, 8'd0);
    send_item(0, 0, 0, rand_word(), 0);

    set_config(MODE_PROVER, 6'd1, 4'd1, 4'd13, 8'd1);
    send_item(0, 0, 0, rand_word(), 0);
    send_item(0, 1, 0, rand_word(), 0);
    send_item(9, 0, 0, rand_word(), 0);
    send_item(9, 12'd4095, 0, '1, 0);
    send_item(9, 1, 1, rand_word(), 0);

    random_start = items_total;
    phase_end    = items_counted;
    while (items_total - random_start < RandomItems) begin
      progress = items_total - random_start;
      if (progress < RandomItems / 3) begin
        send_idle_pct = 30;
        recv_idle_pct = 70;
      end else if (progress < 2 * RandomItems / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (items_counted >= phase_end) begin
        random_config();
        phase_end = items_counted + $urandom_range(30, 60);
      end
      if ($urandom_range(9) == 0) begin
        noise_item();
      end else begin
        run_sequence();
      end
    end

    wait_idle();
    $display("Run covered %0d input words (%0d accumulated) under %0d register settings,",
             items_total, items_counted, settings_used);
    $display("with %0d output words checked across prover and verifier modes.", checked);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
